// ----- hdl/assert_macros.svh -----
// Assertion macros for the checker file of the box transform block.
// Expects signals named clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled during reset, with a fixed message
`define AABB_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("aabb assertion failed");

// Clocked assertion, disabled during reset, with a caller message
`define AABB_ASSERT_MSG(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

`endif

// ----- hdl/aabb_pkg.sv -----
// Package for the box transform block: number format, op and row codes.
// No dependencies; used by the interfaces, the top level and the checker.
package aabb_pkg;

    localparam int COORD_BITS = 32;
    localparam int FRAC_BITS  = 16;
    localparam int PROD_BITS  = 2 * COORD_BITS;
    localparam int ACC_BITS   = PROD_BITS + 2;
    localparam int OP_BITS    = 2;
    localparam int ROW_BITS   = 2;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [OP_BITS-1:0]           op_t;
    typedef logic [ROW_BITS-1:0]          row_t;

    localparam op_t OP_LOAD_MIN = 2'd0;
    localparam op_t OP_LOAD_MAX = 2'd1;
    localparam op_t OP_ROW      = 2'd2;

    localparam row_t ROW_X = 2'd0;
    localparam row_t ROW_Y = 2'd1;
    localparam row_t ROW_Z = 2'd2;

    localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

endpackage

// ----- hdl/aabb_cmd_if.sv -----
// Command channel of the box transform block: corner loads and matrix rows.
// Depends on aabb_pkg.
interface aabb_cmd_if import aabb_pkg::*; ();
    logic   valid;
    logic   ready;
    op_t    op;
    row_t   row;
    coord_t val0;
    coord_t val1;
    coord_t val2;
    coord_t val3;

    modport source (output valid, op, row, val0, val1, val2, val3, input ready);
    modport sink   (input valid, op, row, val0, val1, val2, val3, output ready);
endinterface

// ----- hdl/aabb_box_if.sv -----
// Result channel of the box transform block: the transformed box.
// Depends on aabb_pkg.
interface aabb_box_if import aabb_pkg::*; ();
    logic   valid;
    logic   ready;
    coord_t min_x;
    coord_t min_y;
    coord_t min_z;
    coord_t max_x;
    coord_t max_y;
    coord_t max_z;
    logic   saturated;

    modport source (output valid, min_x, min_y, min_z, max_x, max_y, max_z, saturated,
                    input ready);
    modport sink   (input valid, min_x, min_y, min_z, max_x, max_y, max_z, saturated,
                    output ready);
endinterface

// ----- hdl/aabb_affine_transform_top.sv -----
// Top level of the box transform block: sequencer around one shared multiplier.
// Depends on aabb_pkg, aabb_cmd_if and aabb_box_if.
//
//   channel | direction | carries
//   cmd     | in        | op, row, val0..val3 (corner load or matrix row)
//   box     | out       | min_x..max_z, saturated (after a row-z transfer)
//
// A corner load leaves cmd.ready high. A matrix row item holds cmd.ready low
// after its transfer: six passes through the shared 32x32 multiplier, one
// for each coefficient and box extent, a step to add the last pair, then a
// rounding step. A finished box waits in the output register; a following
// row-z item stalls in its rounding step until that register is free.
// Reset clears the held box to zero and empties the output register.
module aabb_affine_transform_top import aabb_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    aabb_cmd_if.sink  cmd,
    aabb_box_if.source box
);

    localparam logic [2:0] MUL_STEPS = 3'd6;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_MUL  = 3'b010,
        S_RND  = 3'b100
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] cnt_reg, cnt_next;

    coord_t coef_reg [0:2];
    coord_t box_reg  [0:5];
    coord_t part_reg [0:3];
    row_t   row_reg;
    logic   sat_seen_reg;

    logic signed [PROD_BITS-1:0] prod_reg, first_reg, prod_full, pmin, pmax;
    logic signed [ACC_BITS-1:0]  lo_acc_reg, hi_acc_reg, acc_init, lo_sh, hi_sh;

    coord_t mul_a, mul_b, lo_val, hi_val;
    logic   lo_fit, hi_fit, clip;

    coord_t out_min_x_reg, out_min_y_reg, out_min_z_reg;
    coord_t out_max_x_reg, out_max_y_reg, out_max_z_reg;
    logic   out_sat_reg, out_valid_reg;

    logic cmd_xfer, row_ok, emit, rnd_done;

    // Handshake and sequencing conditions
    assign cmd.ready = (state_reg == S_IDLE);
    assign cmd_xfer  = cmd.valid && cmd.ready;
    assign row_ok    = (cmd.op == OP_ROW) &&
                       (cmd.row == ROW_X || cmd.row == ROW_Y || cmd.row == ROW_Z);
    assign emit      = (state_reg == S_RND) && (row_reg == ROW_Z) &&
                       (!out_valid_reg || box.ready);
    assign rnd_done  = (state_reg == S_RND) && ((row_reg != ROW_Z) || emit);

    // Select multiplier operands: coefficient against min then max extent
    always_comb
    begin
        case (cnt_reg)
            3'd0:    begin mul_a = coef_reg[0]; mul_b = box_reg[0]; end
            3'd1:    begin mul_a = coef_reg[0]; mul_b = box_reg[3]; end
            3'd2:    begin mul_a = coef_reg[1]; mul_b = box_reg[1]; end
            3'd3:    begin mul_a = coef_reg[1]; mul_b = box_reg[4]; end
            3'd4:    begin mul_a = coef_reg[2]; mul_b = box_reg[2]; end
            3'd5:    begin mul_a = coef_reg[2]; mul_b = box_reg[5]; end
            default: begin mul_a = '0;          mul_b = '0;          end
        endcase
    end

    // Shared multiplier
    assign prod_full = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);

    // Pick the smaller and larger product of the current pair
    assign pmin = (first_reg < prod_reg) ? first_reg : prod_reg;
    assign pmax = (first_reg < prod_reg) ? prod_reg : first_reg;

    // Start value: translation scaled up, plus half an LSB for rounding
    assign acc_init = (ACC_BITS'(cmd.val3) <<< FRAC_BITS) +
                      (ACC_BITS'(1) << (FRAC_BITS - 1));

    // Round, then clip to the coordinate range
    always_comb
    begin
        lo_sh  = lo_acc_reg >>> FRAC_BITS;
        hi_sh  = hi_acc_reg >>> FRAC_BITS;
        lo_fit = (&lo_sh[ACC_BITS-1:COORD_BITS-1]) | ~(|lo_sh[ACC_BITS-1:COORD_BITS-1]);
        hi_fit = (&hi_sh[ACC_BITS-1:COORD_BITS-1]) | ~(|hi_sh[ACC_BITS-1:COORD_BITS-1]);
        lo_val = lo_fit ? lo_sh[COORD_BITS-1:0] : (lo_sh[ACC_BITS-1] ? COORD_MIN : COORD_MAX);
        hi_val = hi_fit ? hi_sh[COORD_BITS-1:0] : (hi_sh[ACC_BITS-1] ? COORD_MIN : COORD_MAX);
        clip   = !lo_fit || !hi_fit;
    end

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_xfer && row_ok)
                begin
                    state_next = S_MUL;
                    cnt_next   = '0;
                end
            end
            S_MUL:
            begin
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == MUL_STEPS)
                begin
                    state_next = S_RND;
                end
            end
            S_RND:
            begin
                if (rnd_done)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state, held box and saturation history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            sat_seen_reg  <= 1'b0;
            for (int i = 0; i < 6; i++)
            begin
                box_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;

            // Hold the result until the sink takes it
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (box.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            // Load a corner
            if (cmd_xfer && cmd.op == OP_LOAD_MIN)
            begin
                box_reg[0] <= cmd.val0;
                box_reg[1] <= cmd.val1;
                box_reg[2] <= cmd.val2;
            end
            else if (cmd_xfer && cmd.op == OP_LOAD_MAX)
            begin
                box_reg[3] <= cmd.val0;
                box_reg[4] <= cmd.val1;
                box_reg[5] <= cmd.val2;
            end

            // Replace the box and restart saturation history on a result
            if (emit)
            begin
                box_reg[0]   <= part_reg[0];
                box_reg[1]   <= part_reg[1];
                box_reg[2]   <= lo_val;
                box_reg[3]   <= part_reg[2];
                box_reg[4]   <= part_reg[3];
                box_reg[5]   <= hi_val;
                sat_seen_reg <= 1'b0;
            end
            else if (rnd_done)
            begin
                sat_seen_reg <= sat_seen_reg | clip;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        // Capture the row on its transfer
        if (cmd_xfer && row_ok)
        begin
            coef_reg[0] <= cmd.val0;
            coef_reg[1] <= cmd.val1;
            coef_reg[2] <= cmd.val2;
            row_reg     <= cmd.row;
            lo_acc_reg  <= acc_init;
            hi_acc_reg  <= acc_init;
        end

        // Advance the multiply and accumulate the pair extremes
        if (state_reg == S_MUL)
        begin
            prod_reg <= prod_full;
            if (cnt_reg != 3'd0)
            begin
                if (cnt_reg[0])
                begin
                    first_reg <= prod_reg;
                end
                else
                begin
                    lo_acc_reg <= lo_acc_reg + ACC_BITS'(pmin);
                    hi_acc_reg <= hi_acc_reg + ACC_BITS'(pmax);
                end
            end
        end

        // Keep x and y extremes until the z row arrives
        if (rnd_done && row_reg == ROW_X)
        begin
            part_reg[0] <= lo_val;
            part_reg[2] <= hi_val;
        end
        if (rnd_done && row_reg == ROW_Y)
        begin
            part_reg[1] <= lo_val;
            part_reg[3] <= hi_val;
        end

        // Load the output register
        if (emit)
        begin
            out_min_x_reg <= part_reg[0];
            out_min_y_reg <= part_reg[1];
            out_min_z_reg <= lo_val;
            out_max_x_reg <= part_reg[2];
            out_max_y_reg <= part_reg[3];
            out_max_z_reg <= hi_val;
            out_sat_reg   <= sat_seen_reg | clip;
        end
    end

    assign box.valid     = out_valid_reg;
    assign box.min_x     = out_min_x_reg;
    assign box.min_y     = out_min_y_reg;
    assign box.min_z     = out_min_z_reg;
    assign box.max_x     = out_max_x_reg;
    assign box.max_y     = out_max_y_reg;
    assign box.max_z     = out_max_z_reg;
    assign box.saturated = out_sat_reg;

endmodule

// ----- hdl/aabb_chk.sv -----
// Port-level checker for the box transform block, bound to its top level.
// Depends on aabb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module aabb_chk import aabb_pkg::*;
(
    input logic   clk,
    input logic   rst_n,
    input logic   cmd_valid,
    input logic   cmd_ready,
    input op_t    cmd_op,
    input row_t   cmd_row,
    input logic   box_valid,
    input logic   box_ready,
    input coord_t box_min_x
);

    logic row_xfer, load_xfer;

    assign row_xfer  = cmd_valid && cmd_ready && cmd_op == OP_ROW &&
                       (cmd_row == ROW_X || cmd_row == ROW_Y || cmd_row == ROW_Z);
    assign load_xfer = cmd_valid && cmd_ready &&
                       (cmd_op == OP_LOAD_MIN || cmd_op == OP_LOAD_MAX);

    // A stalled result stays valid and keeps its min_x
    `AABB_ASSERT(a_box_hold, box_valid && !box_ready |=> box_valid && $stable(box_min_x))

    // A row transfer keeps the block busy
    `AABB_ASSERT_MSG(a_row_busy, row_xfer |=> !cmd_ready, "row transfer left block ready")

    // A corner load finishes at once
    `AABB_ASSERT_MSG(a_load_quick, load_xfer |=> cmd_ready, "corner load stalled the block")

    // A new result appears only at the end of busy work
    `AABB_ASSERT(a_box_from_work, $rose(box_valid) |-> $past(!cmd_ready))

endmodule

bind aabb_affine_transform_top aabb_chk u_aabb_chk
(
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .cmd_op    (cmd.op),
    .cmd_row   (cmd.row),
    .box_valid (box.valid),
    .box_ready (box.ready),
    .box_min_x (box.min_x)
);
